// ----- rtl/isadma_pkg.sv -----
// Shared types, constants and port lookup functions for the ISA DMA channel programmer.
// No dependencies.
package isadma_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_NOENT  = 3'd1;
   localparam logic [2:0] ST_NOTSUP = 3'd2;
   localparam logic [2:0] ST_INVAL  = 3'd3;
   localparam logic [2:0] ST_NOINIT = 3'd4;

   localparam logic       REQ_SETUP = 1'b0;
   localparam logic       REQ_QUERY = 1'b1;

   localparam logic [7:0] PORT_MASTER_RESET_16 = 8'hda;
   localparam logic [7:0] PORT_MASTER_RESET_8  = 8'h0d;
   localparam logic [7:0] MASTER_RESET_DATA    = 8'hff;
   localparam logic [7:0] PORT_FF_8    = 8'h0c;
   localparam logic [7:0] PORT_FF_16   = 8'hd8;
   localparam logic [7:0] PORT_MASK_8  = 8'h0a;
   localparam logic [7:0] PORT_MASK_16 = 8'hd4;
   localparam logic [7:0] PORT_MODE_8  = 8'h0b;
   localparam logic [7:0] PORT_MODE_16 = 8'hd6;

   // One classified item, handed from the front end to the sequencer.
   typedef struct packed {
      logic [2:0]  status;
      logic        init_pre;   // emit the two master-reset writes first
      logic        prog;       // emit the ten channel programming writes
      logic        one_pv;     // single-result form: port write flag
      logic [7:0]  one_port;
      logic [7:0]  one_data;
      logic [16:0] remaining;
      logic        wide;
      logic [2:0]  ch;
      logic [7:0]  mode;
      logic [23:0] addr;
      logic [15:0] cnt;
   } desc_type;

   function automatic logic [7:0] addr_port(input logic [2:0] ch);
      logic [7:0] p;
      case (ch)
         3'd0: p = 8'h00;
         3'd1: p = 8'h02;
         3'd2: p = 8'h04;
         3'd3: p = 8'h06;
         3'd4: p = 8'hc0;
         3'd5: p = 8'hc4;
         3'd6: p = 8'hc8;
         default: p = 8'hcc;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] count_port(input logic [2:0] ch);
      logic [7:0] p;
      case (ch)
         3'd0: p = 8'h01;
         3'd1: p = 8'h03;
         3'd2: p = 8'h05;
         3'd3: p = 8'h07;
         3'd4: p = 8'hc2;
         3'd5: p = 8'hc6;
         3'd6: p = 8'hca;
         default: p = 8'hce;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] page_port(input logic [2:0] ch);
      logic [7:0] p;
      case (ch)
         3'd0: p = 8'h87;
         3'd1: p = 8'h83;
         3'd2: p = 8'h81;
         3'd3: p = 8'h82;
         3'd4: p = 8'h8f;
         3'd5: p = 8'h8b;
         3'd6: p = 8'h89;
         default: p = 8'h8a;
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/isadma_front.sv -----
// Front end: checks each request, classifies it and tracks the controller init flag.
// Depends on isadma_pkg.
module isadma_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  req_type,
   input  logic [3:0]            req_channel,
   input  logic [31:0]           req_buffer_address,
   input  logic [31:0]           req_transfer_size,
   input  logic [7:0]            req_mode_byte,
   input  logic [15:0]           req_raw_count,
   output isadma_pkg::desc_type  desc
);
   import isadma_pkg::*;

   logic        init_done_ff, init_done_in;
   logic        wide;
   logic [1:0]  sel;
   logic [31:0] end_addr;
   logic        bad_range;
   logic [31:0] size_eff;
   logic [31:0] cnt_full;

   assign wide      = req_channel[2];
   assign sel       = req_channel[1:0];
   assign end_addr  = req_buffer_address + req_transfer_size - 32'd1;
   assign bad_range = (req_buffer_address[31:24] != 8'd0)
                   || (!wide && req_buffer_address[23:20] != 4'd0)
                   || (req_buffer_address[31:16] != end_addr[31:16]);
   assign size_eff  = wide ? {1'b0, req_transfer_size[31:1]} : req_transfer_size;
   assign cnt_full  = size_eff - 32'd1;

   always_comb begin
      desc           = '0;
      desc.wide      = wide;
      desc.ch        = req_channel[2:0];
      desc.mode      = req_mode_byte | {6'd0, sel};
      desc.addr      = wide ? {req_buffer_address[23:16], req_buffer_address[16:1]}
                            : req_buffer_address[23:0];
      desc.cnt       = cnt_full[15:0];
      if (req_channel[3]) begin
         desc.status = ST_NOENT;
      end else if (sel == 2'd0) begin
         desc.status = ST_NOTSUP;
      end else if (req_type == REQ_QUERY) begin
         if (!init_done_ff) begin
            desc.status = ST_NOINIT;
         end else begin
            desc.status    = ST_OK;
            desc.one_pv    = 1'b1;
            desc.one_port  = wide ? PORT_FF_16 : PORT_FF_8;
            desc.remaining = wide ? ({1'b0, req_raw_count[14:0], 1'b0} + 17'd2)
                                  : ({1'b0, req_raw_count} + 17'd1);
         end
      end else if (bad_range) begin
         desc.status = ST_INVAL;
      end else begin
         desc.init_pre = !init_done_ff;
         if (wide && req_transfer_size[0]) begin
            desc.status = ST_INVAL;
         end else begin
            desc.status = ST_OK;
            desc.prog   = 1'b1;
         end
      end
   end

   assign init_done_in = init_done_ff | (accept & desc.init_pre);

   always_ff @(posedge clock) begin
      if (reset) begin
         init_done_ff <= 1'b0;
      end else begin
         init_done_ff <= init_done_in;
      end
   end

endmodule

// ----- rtl/isadma_fifo.sv -----
// Short descriptor queue between the front end and the sequencer.
// Depends on isadma_pkg.
module isadma_fifo #(
   parameter int DEPTH = isadma_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  isadma_pkg::desc_type  push_desc,
   input  logic                  pop,
   output isadma_pkg::desc_type  head,
   output logic                  empty,
   output logic                  full
);
   import isadma_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        mem_ff [DEPTH];
   logic [IW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [IW-1:0] next_ptr(input logic [IW-1:0] p);
      return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/isadma_back.sv -----
// Sequencer: walks a descriptor through its port writes into the result register.
// Depends on isadma_pkg.
module isadma_back (
   input  logic                  clock,
   input  logic                  reset,
   input  isadma_pkg::desc_type  head,
   input  logic                  head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic                  rsp_port_valid,
   output logic [7:0]            rsp_port_address,
   output logic [7:0]            rsp_port_data,
   output logic [16:0]           rsp_remaining_bytes,
   output logic                  rsp_last
);
   import isadma_pkg::*;

   localparam logic [3:0] STEP_RST0   = 4'd0;
   localparam logic [3:0] STEP_RST1   = 4'd1;
   localparam logic [3:0] STEP_MASK   = 4'd2;
   localparam logic [3:0] STEP_MODE   = 4'd3;
   localparam logic [3:0] STEP_FF0    = 4'd4;
   localparam logic [3:0] STEP_ADDRL  = 4'd5;
   localparam logic [3:0] STEP_ADDRH  = 4'd6;
   localparam logic [3:0] STEP_PAGE   = 4'd7;
   localparam logic [3:0] STEP_FF1    = 4'd8;
   localparam logic [3:0] STEP_CNTL   = 4'd9;
   localparam logic [3:0] STEP_CNTH   = 4'd10;
   localparam logic [3:0] STEP_UNMASK = 4'd11;

   logic        busy_ff, busy_in;
   logic [3:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [2:0]  status_ff;
   logic        pv_ff;
   logic [7:0]  port_ff, data_ff;
   logic [16:0] rem_ff;
   logic        last_ff;

   logic        emit;
   logic [3:0]  cur_step;
   logic        cur_last;
   logic        n_pv;
   logic [7:0]  n_port, n_data;
   logic [16:0] n_rem;
   logic [7:0]  p_ff, p_mask, p_mode;
   logic [1:0]  sel;

   assign cur_step = busy_ff ? step_ff : (head.init_pre ? STEP_RST0 : STEP_MASK);
   assign cur_last = head.prog ? (cur_step == STEP_UNMASK) : (cur_step == STEP_MASK);
   assign emit     = head_valid && (!valid_ff || rsp_ready);
   assign pop      = emit && cur_last;

   assign sel    = head.ch[1:0];
   assign p_ff   = head.wide ? PORT_FF_16   : PORT_FF_8;
   assign p_mask = head.wide ? PORT_MASK_16 : PORT_MASK_8;
   assign p_mode = head.wide ? PORT_MODE_16 : PORT_MODE_8;

   always_comb begin
      n_pv   = 1'b1;
      n_port = 8'd0;
      n_data = 8'd0;
      n_rem  = 17'd0;
      case (cur_step)
         STEP_RST0: begin
            n_port = PORT_MASTER_RESET_16;
            n_data = MASTER_RESET_DATA;
         end
         STEP_RST1: begin
            n_port = PORT_MASTER_RESET_8;
            n_data = MASTER_RESET_DATA;
         end
         STEP_MASK: begin
            if (head.prog) begin
               n_port = p_mask;
               n_data = {6'd1, sel};
            end else begin
               // single-result form: errors, queries, odd 16-bit size
               n_pv   = head.one_pv;
               n_port = head.one_port;
               n_data = head.one_data;
               n_rem  = head.remaining;
            end
         end
         STEP_MODE: begin
            n_port = p_mode;
            n_data = head.mode;
         end
         STEP_FF0, STEP_FF1: begin
            n_port = p_ff;
         end
         STEP_ADDRL: begin
            n_port = addr_port(head.ch);
            n_data = head.addr[7:0];
         end
         STEP_ADDRH: begin
            n_port = addr_port(head.ch);
            n_data = head.addr[15:8];
         end
         STEP_PAGE: begin
            n_port = page_port(head.ch);
            n_data = head.addr[23:16];
         end
         STEP_CNTL: begin
            n_port = count_port(head.ch);
            n_data = head.cnt[7:0];
         end
         STEP_CNTH: begin
            n_port = count_port(head.ch);
            n_data = head.cnt[15:8];
         end
         STEP_UNMASK: begin
            n_port = p_mask;
            n_data = {6'd0, sel};
         end
         default: begin
            n_pv = 1'b0;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
         busy_in  = !cur_last;
         step_in  = cur_step + 4'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= STEP_RST0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff <= head.status;
         pv_ff     <= n_pv;
         port_ff   <= n_port;
         data_ff   <= n_data;
         rem_ff    <= n_rem;
         last_ff   <= cur_last;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_port_valid      = pv_ff;
   assign rsp_port_address    = port_ff;
   assign rsp_port_data       = data_ff;
   assign rsp_remaining_bytes = rem_ff;
   assign rsp_last            = last_ff;

endmodule

// ----- rtl/isa_dma_channel_programmer.sv -----
// Top level of the ISA DMA channel programmer: front end, descriptor queue, sequencer.
// Depends on isadma_pkg, isadma_front, isadma_fifo and isadma_back.
//
// Usage:
//   Request channel (req_*): one transfer is either a channel setup (req_type 0) or a
//   remaining-count query (req_type 1). The front end checks and classifies it in the
//   cycle it is accepted and pushes one descriptor into a short queue.
//   Result channel (rsp_*): the sequencer turns each descriptor into its results, one
//   per cycle unless stalled; rsp_last marks the final result of a request. A setup
//   gives ten port writes, twelve on the first good setup (two master-reset writes
//   lead). Errors, queries and a rejected odd 16-bit size give a single result, except
//   that an odd 16-bit size on the first setup to pass the limit checks gives three.
//   Each descriptor is registered in the queue, and each result in the result
//   register. Throughput: one result per cycle while rsp_ready is high or the result
//   register is empty; the single result register and the sequencer's step counter
//   set that rate.
//   req_ready stays high while the queue has room, so requests keep coming in while a
//   finished result waits on rsp_ready.
//   Stall: with rsp_ready low the result register holds its payload, the sequencer
//   holds its step, and the queue fills; then req_ready drops.
//   Reset: empties the queue and the result register and clears the init flag, so the
//   next good setup again emits the master-reset writes.
module isa_dma_channel_programmer #(
   parameter int QUEUE_DEPTH = isadma_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [3:0]  req_channel,
   input  logic [31:0] req_buffer_address,
   input  logic [31:0] req_transfer_size,
   input  logic [7:0]  req_mode_byte,
   input  logic [15:0] req_raw_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_port_valid,
   output logic [7:0]  rsp_port_address,
   output logic [7:0]  rsp_port_data,
   output logic [16:0] rsp_remaining_bytes,
   output logic        rsp_last
);
   import isadma_pkg::*;

   desc_type front_desc;
   desc_type head;
   logic     accept;
   logic     q_empty, q_full, q_pop;

   // take a request whenever the queue has room
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   isadma_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_type           (req_type),
      .req_channel        (req_channel),
      .req_buffer_address (req_buffer_address),
      .req_transfer_size  (req_transfer_size),
      .req_mode_byte      (req_mode_byte),
      .req_raw_count      (req_raw_count),
      .desc               (front_desc)
   );

   isadma_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_desc (front_desc),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // advance the sequencer only while a descriptor waits at the queue head
   isadma_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .head_valid          (!q_empty),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_port_valid      (rsp_port_valid),
      .rsp_port_address    (rsp_port_address),
      .rsp_port_data       (rsp_port_data),
      .rsp_remaining_bytes (rsp_remaining_bytes),
      .rsp_last            (rsp_last)
   );

endmodule

// ----- dv/isadma_ledger_pkg.sv -----
// Scoreboard for the ISA DMA channel programmer: it predicts the port writes of each
// accepted request and checks the results in order. Depends on isadma_pkg.
package isadma_ledger_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import isadma_pkg::*;

   localparam logic [7:0] ADDR_PORTS  [8] = '{8'h00, 8'h02, 8'h04, 8'h06,
                                              8'hc0, 8'hc4, 8'hc8, 8'hcc};
   localparam logic [7:0] COUNT_PORTS [8] = '{8'h01, 8'h03, 8'h05, 8'h07,
                                              8'hc2, 8'hc6, 8'hca, 8'hce};
   localparam logic [7:0] PAGE_PORTS  [8] = '{8'h87, 8'h83, 8'h81, 8'h82,
                                              8'h8f, 8'h8b, 8'h89, 8'h8a};

   typedef struct packed {
      logic [2:0]  status;
      logic        port_valid;
      logic [7:0]  port_address;
      logic [7:0]  port_data;
      logic [16:0] remaining;
      logic        last;
   } dma_result_t;

   class port_write_ledger;
      dma_result_t pending[$];
      dma_result_t batch[$];
      logic        init_done;
      int          errors;

      function new();
         init_done = 1'b0;
         errors = 0;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function void emit(logic pv, logic [7:0] port, logic [7:0] data, logic [16:0] rem);
         dma_result_t r;
         r = '0;
         r.port_valid = pv;
         r.port_address = port;
         r.port_data = data;
         r.remaining = rem;
         batch.push_back(r);
      endfunction

      // Stamp the final status on every result of the request and mark the last one.
      function void seal(logic [2:0] st);
         foreach (batch[i]) batch[i].status = st;
         batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) pending.push_back(batch[i]);
         batch.delete();
      endfunction

      function void note_request(logic kind, logic [3:0] ch, logic [31:0] pa,
                                 logic [31:0] size, logic [7:0] mode, logic [15:0] raw);
         logic        wide;
         logic [1:0]  sel;
         logic [7:0]  ff_port;
         logic [7:0]  mask_port;
         logic [7:0]  mode_port;
         logic [31:0] last_byte;
         logic [31:0] words;
         logic [31:0] addr;
         logic [31:0] cnt;
         wide = (ch >= 4'd4);
         sel = ch[1:0];
         ff_port = wide ? PORT_FF_16 : PORT_FF_8;
         mask_port = wide ? PORT_MASK_16 : PORT_MASK_8;
         mode_port = wide ? PORT_MODE_16 : PORT_MODE_8;
         batch.delete();
         if (ch > 4'd7) begin
            emit(1'b0, 8'h00, 8'h00, 17'd0);
            seal(ST_NOENT);
            return;
         end
         if (sel == 2'd0) begin
            emit(1'b0, 8'h00, 8'h00, 17'd0);
            seal(ST_NOTSUP);
            return;
         end
         if (kind == REQ_QUERY) begin
            if (!init_done) begin
               emit(1'b0, 8'h00, 8'h00, 17'd0);
               seal(ST_NOINIT);
               return;
            end
            if (wide)
               emit(1'b1, ff_port, 8'h00, 17'({raw[14:0], 1'b0}) + 17'd2);
            else
               emit(1'b1, ff_port, 8'h00, 17'(raw) + 17'd1);
            seal(ST_OK);
            return;
         end
         last_byte = pa + size - 32'd1;
         if (pa >= 32'h0100_0000 || (!wide && pa >= 32'h0010_0000) ||
             pa[31:16] != last_byte[31:16]) begin
            emit(1'b0, 8'h00, 8'h00, 17'd0);
            seal(ST_INVAL);
            return;
         end
         if (!init_done) begin
            init_done = 1'b1;
            emit(1'b1, PORT_MASTER_RESET_16, MASTER_RESET_DATA, 17'd0);
            emit(1'b1, PORT_MASTER_RESET_8, MASTER_RESET_DATA, 17'd0);
         end
         if (wide) begin
            if (size[0]) begin
               emit(1'b0, 8'h00, 8'h00, 17'd0);
               seal(ST_INVAL);
               return;
            end
            words = size >> 1;
            addr = {8'h00, pa[23:16], pa[16:1]};
         end else begin
            words = size;
            addr = pa;
         end
         cnt = words - 32'd1;
         emit(1'b1, mask_port, {6'd0, sel} | 8'h04, 17'd0);
         emit(1'b1, mode_port, {6'd0, sel} | mode, 17'd0);
         emit(1'b1, ff_port, 8'h00, 17'd0);
         emit(1'b1, ADDR_PORTS[ch[2:0]], addr[7:0], 17'd0);
         emit(1'b1, ADDR_PORTS[ch[2:0]], addr[15:8], 17'd0);
         emit(1'b1, PAGE_PORTS[ch[2:0]], addr[23:16], 17'd0);
         emit(1'b1, ff_port, 8'h00, 17'd0);
         emit(1'b1, COUNT_PORTS[ch[2:0]], cnt[7:0], 17'd0);
         emit(1'b1, COUNT_PORTS[ch[2:0]], cnt[15:8], 17'd0);
         emit(1'b1, mask_port, {6'd0, sel}, 17'd0);
         seal(ST_OK);
      endfunction

      function void compare(string field, logic [16:0] want, logic [16:0] got);
         if (got !== want) begin
            $display("%0t: rsp_%s expected 0x%0h, got 0x%0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_write(logic [2:0] st, logic pv, logic [7:0] port,
                                logic [7:0] data, logic [16:0] rem, logic lst);
         dma_result_t want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result expected none, got status 0x%0h port 0x%0h",
                     $time, st, port);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare("status", 17'(want.status), 17'(st));
         compare("port_valid", 17'(want.port_valid), 17'(pv));
         compare("port_address", 17'(want.port_address), 17'(port));
         compare("port_data", 17'(want.port_data), 17'(data));
         compare("remaining_bytes", want.remaining, rem);
         compare("last", 17'(want.last), 17'(lst));
      endfunction
   endclass

endpackage

// ----- dv/testbench.sv -----
// Top-level testbench for isa_dma_channel_programmer: directed and random setup and
// query requests with random idling on both sides. Depends on isadma_pkg and isadma_ledger_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isadma_pkg::*;
   import isadma_ledger_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;
   localparam int RUSH_ITEMS   = 10;
   localparam int RANDOM_ITEMS = 125;
   localparam int SETTLE       = 16;
   localparam logic [3:0] LIVE_CHANNELS [6] = '{4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_SETUP;
   logic [3:0]  req_channel = '0;
   logic [31:0] req_buffer_address = '0;
   logic [31:0] req_transfer_size = '0;
   logic [7:0]  req_mode_byte = '0;
   logic [15:0] req_raw_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_port_valid;
   logic [7:0]  rsp_port_address;
   logic [7:0]  rsp_port_data;
   logic [16:0] rsp_remaining_bytes;
   logic        rsp_last;

   port_write_ledger ledger = new();

   // Sender and receiver idling state: a calm count forces back-to-back transfers.
   int   tx_calm = 0;
   int   rx_calm = 0;
   int   rush = 0;          // sender items to offer with no gap at all
   logic hold_request = 1'b0;

   isa_dma_channel_programmer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_channel        (req_channel),
      .req_buffer_address (req_buffer_address),
      .req_transfer_size  (req_transfer_size),
      .req_mode_byte      (req_mode_byte),
      .req_raw_count      (req_raw_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_port_valid     (rsp_port_valid),
      .rsp_port_address   (rsp_port_address),
      .rsp_port_data      (rsp_port_data),
      .rsp_remaining_bytes(rsp_remaining_bytes),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Draw the wait before the next transfer from a uniform random range, with runs of none.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // Offer one request and hold it until the transfer. Valid is left high on return,
   // so the next call either keeps it up (no gap) or drops it.
   task automatic send_request(input logic kind, input logic [3:0] ch, input logic [31:0] pa,
                               input logic [31:0] size, input logic [7:0] mode,
                               input logic [15:0] raw);
      int gap;
      if (rush > 0) begin
         rush--;
         gap = 0;
      end else begin
         gap = draw_wait(tx_calm);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_channel <= ch;
      req_buffer_address <= pa;
      req_transfer_size <= size;
      req_mode_byte <= mode;
      req_raw_count <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_request(kind, ch, pa, size, mode, raw);
   endtask

   // Drop valid and hold off until every predicted result has been checked.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.outstanding() != 0);
   endtask

   task automatic run_directed();
      // queries before any setup, bad channels on both request kinds
      send_request(REQ_QUERY, 4'd1, 32'h0, 32'h0, 8'h00, 16'h1234);
      send_request(REQ_QUERY, 4'd9, 32'h0, 32'h0, 8'h00, 16'hffff);
      send_request(REQ_QUERY, 4'd4, 32'h0, 32'h0, 8'h00, 16'h0001);
      send_request(REQ_SETUP, 4'd15, 32'h1000, 32'h10, 8'h44, 16'h0);
      send_request(REQ_SETUP, 4'd0, 32'h1000, 32'h10, 8'h44, 16'h0);
      send_request(REQ_SETUP, 4'd4, 32'h1000, 32'h10, 8'h44, 16'h0);
      // buffer limit violations: 1 MB on 8-bit, 16 MB, 64 KB crossing
      send_request(REQ_SETUP, 4'd1, 32'h0010_0000, 32'h10, 8'h44, 16'h0);
      send_request(REQ_SETUP, 4'd5, 32'h0100_0000, 32'h10, 8'h44, 16'h0);
      send_request(REQ_SETUP, 4'd2, 32'h0000_fff0, 32'h20, 8'h44, 16'h0);
      // first passing setup is an odd 16-bit size: master reset, then rejection
      send_request(REQ_SETUP, 4'd6, 32'h0002_0000, 32'h101, 8'h58, 16'h0);
      send_request(REQ_SETUP, 4'd6, 32'h0002_0000, 32'h100, 8'h00, 16'h0);
      send_request(REQ_SETUP, 4'd1, 32'h0001_2345, 32'h100, 8'h48, 16'h0);
      send_request(REQ_SETUP, 4'd7, 32'h00ff_0000, 32'h0001_0000, 8'hff, 16'h0);
      // zero size wraps the count to all ones when it stays inside the page
      send_request(REQ_SETUP, 4'd3, 32'h000f_0001, 32'h0, 8'h54, 16'h0);
      send_request(REQ_SETUP, 4'd5, 32'h0, 32'h0, 8'h54, 16'h0);
      send_request(REQ_SETUP, 4'd5, 32'h0001_0002, 32'h0, 8'h54, 16'h0);
      send_request(REQ_SETUP, 4'd2, 32'h000f_ffff, 32'h1, 8'h44, 16'h0);
      send_request(REQ_SETUP, 4'd1, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
      send_request(REQ_SETUP, 4'd7, 32'h00ff_fffe, 32'h2, 8'h88, 16'h0);
      // count readback at the extremes, 8-bit and 16-bit
      send_request(REQ_QUERY, 4'd1, 32'h0, 32'h0, 8'h00, 16'h0000);
      send_request(REQ_QUERY, 4'd3, 32'h0, 32'h0, 8'h00, 16'hffff);
      send_request(REQ_QUERY, 4'd5, 32'h0, 32'h0, 8'h00, 16'hffff);
      send_request(REQ_QUERY, 4'd6, 32'h0, 32'h0, 8'h00, 16'h0000);
      send_request(REQ_QUERY, 4'd7, 32'h0, 32'h0, 8'h00, 16'h8000);
      send_request(REQ_QUERY, 4'd2, 32'h0, 32'h0, 8'h00, 16'h7fff);
   endtask

   task automatic send_random_item();
      logic [3:0]  ch;
      logic [31:0] pa;
      logic [31:0] size;
      logic [31:0] off;
      int          pick;
      pick = $urandom_range(0, 19);
      ch = LIVE_CHANNELS[$urandom_range(0, 5)];
      if (pick < 12) begin
         // well-formed setup that stays inside one 64 KB page
         if (ch >= 4'd4) begin
            off = 2 * $urandom_range(0, 32767);
            size = 2 * $urandom_range(1, (65536 - off) / 2);
            pa = {8'h00, 8'($urandom_range(0, 255)), 16'h0000} + off;
         end else begin
            off = $urandom_range(0, 65535);
            size = $urandom_range(1, 65536 - off);
            pa = {12'h000, 4'($urandom_range(0, 15)), 16'h0000} + off;
         end
         send_request(REQ_SETUP, ch, pa, size, 8'($urandom), 16'($urandom));
      end else if (pick < 16) begin
         send_request(REQ_QUERY, ch, $urandom, $urandom, 8'($urandom), 16'($urandom));
      end else if (pick < 18) begin
         // near the limits: any channel, addresses around 16 MB, sizes around 64 KB
         send_request(1'($urandom), 4'($urandom), $urandom & 32'h01ff_ffff,
                      $urandom_range(0, 70000), 8'($urandom), 16'($urandom));
      end else begin
         send_request(1'($urandom), 4'($urandom), $urandom, $urandom,
                      8'($urandom), 16'($urandom));
      end
   endtask

   // Receiver: accept results with random waits; on request, hold off for a long
   // stretch so the queue fills and the block drops req_ready.
   initial begin
      int gap;
      int held;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = draw_wait(rx_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         ledger.check_write(rsp_status, rsp_port_valid, rsp_port_address, rsp_port_data,
                            rsp_remaining_bytes, rsp_last);
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("isa_dma_channel_programmer verification failed");
      $finish;
   end

   initial begin
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drained();
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 50) begin
            // stall the result side while requests keep coming back to back
            hold_request = 1'b1;
            rush = RUSH_ITEMS;
         end
         if (n == 100) wait_drained();
         send_random_item();
      end
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (ledger.errors == 0)
         $display("isa_dma_channel_programmer verification clean");
      else
         $display("isa_dma_channel_programmer verification failed");
      $finish;
   end

endmodule
